// ===== sv/yuy2_pair_to_rgb_macros.svh =====
// Assertion macros used by the yuy2_pair_to_rgb top level.
`ifndef YUY2_PAIR_TO_RGB_MACROS_SVH
`define YUY2_PAIR_TO_RGB_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define YP2R_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("yp2r assertion failed");

// Check that a trigger leads to a consequence starting in the next cycle.
`define YP2R_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("yp2r assertion failed");

`endif

// ===== sv/yp2r_pkg.sv =====
// Shared types, coefficients and helpers for the YUY2 to RGB converter.
`timescale 1ns / 1ps
package yp2r_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // Coefficient magnitudes with 24 fraction bits.
    localparam longint KY24  = 64'sd19535115;
    localparam longint KRV24 = 64'sd26916147;
    localparam longint KGU24 = 64'sd6599540;
    localparam longint KGV24 = 64'sd13697882;
    localparam longint KBU24 = 64'sd33956935;

    localparam int COEF_FRAC_SRC = 24;
    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;
    localparam logic [7:0] CHANNEL_MAX   = 8'd255;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
    } t_yuy2_in;

    typedef struct packed {
        logic [23:0] rgb_first;
        logic [23:0] rgb_second;
    } t_rgb_out;

    // Round a 24-fraction-bit coefficient half up to fb fraction bits.
    function automatic longint to_frac(input longint k24, input int fb);
        longint drop;
        drop = longint'(COEF_FRAC_SRC - fb);
        return (k24 + ((64'sd1 <<< drop) >>> 1)) >>> drop;
    endfunction

    // Remove the byte offset and widen to a signed 9-bit difference.
    function automatic logic signed [8:0] offset_diff(input logic [7:0] val,
                                                      input logic [7:0] ofs);
        return $signed({1'b0, val}) - $signed({1'b0, ofs});
    endfunction

endpackage

// ===== sv/yp2r_chroma.sv =====
// Shared chroma product unit: four coefficient products registered once per beat.
`timescale 1ns / 1ps
module yp2r_chroma #(
    parameter int FRACTION_BITS = yp2r_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic [7:0]                     i_chroma_blue,
    input  logic [7:0]                     i_chroma_red,
    output logic signed [FRACTION_BITS+11:0] o_rv,
    output logic signed [FRACTION_BITS+11:0] o_gu,
    output logic signed [FRACTION_BITS+11:0] o_gv,
    output logic signed [FRACTION_BITS+11:0] o_bu
);
    localparam int PW = FRACTION_BITS + 12;

    localparam logic signed [PW-1:0] C_KRV = PW'(yp2r_pkg::to_frac(yp2r_pkg::KRV24, FRACTION_BITS));
    localparam logic signed [PW-1:0] C_KGU = PW'(yp2r_pkg::to_frac(yp2r_pkg::KGU24, FRACTION_BITS));
    localparam logic signed [PW-1:0] C_KGV = PW'(yp2r_pkg::to_frac(yp2r_pkg::KGV24, FRACTION_BITS));
    localparam logic signed [PW-1:0] C_KBU = PW'(yp2r_pkg::to_frac(yp2r_pkg::KBU24, FRACTION_BITS));

    logic signed [8:0]    w_ud;
    logic signed [8:0]    w_vd;
    logic signed [PW-1:0] w_ud_ext;
    logic signed [PW-1:0] w_vd_ext;
    logic signed [PW-1:0] r_rv;
    logic signed [PW-1:0] r_gu;
    logic signed [PW-1:0] r_gv;
    logic signed [PW-1:0] r_bu;

    assign w_ud     = yp2r_pkg::offset_diff(i_chroma_blue, yp2r_pkg::CHROMA_OFFSET);
    assign w_vd     = yp2r_pkg::offset_diff(i_chroma_red, yp2r_pkg::CHROMA_OFFSET);
    assign w_ud_ext = PW'(w_ud);
    assign w_vd_ext = PW'(w_vd);

    always_ff @(posedge i_clk) begin
        r_rv <= C_KRV * w_vd_ext;
        r_gu <= C_KGU * w_ud_ext;
        r_gv <= C_KGV * w_vd_ext;
        r_bu <= C_KBU * w_ud_ext;
    end

    assign o_rv = r_rv;
    assign o_gu = r_gu;
    assign o_gv = r_gv;
    assign o_bu = r_bu;

endmodule

// ===== sv/yp2r_lane.sv =====
// One pixel lane: luma product, channel sums and clamp to a packed RGB word.
`timescale 1ns / 1ps
module yp2r_lane #(
    parameter int FRACTION_BITS = yp2r_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic [7:0]                       i_luma,
    input  logic signed [FRACTION_BITS+11:0] i_rv,
    input  logic signed [FRACTION_BITS+11:0] i_gu,
    input  logic signed [FRACTION_BITS+11:0] i_gv,
    input  logic signed [FRACTION_BITS+11:0] i_bu,
    output logic [23:0]                      o_pix
);
    localparam int PW = FRACTION_BITS + 12;

    localparam logic signed [PW-1:0] C_KY = PW'(yp2r_pkg::to_frac(yp2r_pkg::KY24, FRACTION_BITS));

    logic signed [8:0]    w_yd;
    logic signed [PW-1:0] r_yterm;
    logic signed [PW-1:0] w_r;
    logic signed [PW-1:0] w_g;
    logic signed [PW-1:0] w_b;
    logic [23:0]          r_pix;

    // Negative sums go to zero, anything at or above 256 saturates.
    function automatic logic [7:0] clamp_channel(input logic signed [PW-1:0] acc);
        logic [7:0] res;
        if (acc[PW-1]) begin
            res = 8'd0;
        end else if (|acc[PW-2:FRACTION_BITS+8]) begin
            res = yp2r_pkg::CHANNEL_MAX;
        end else begin
            res = acc[FRACTION_BITS+7:FRACTION_BITS];
        end
        return res;
    endfunction

    assign w_yd = yp2r_pkg::offset_diff(i_luma, yp2r_pkg::LUMA_OFFSET);

    always_ff @(posedge i_clk) begin
        r_yterm <= C_KY * PW'(w_yd);
    end

    assign w_r = r_yterm + i_rv;
    assign w_g = r_yterm - i_gu - i_gv;
    assign w_b = r_yterm + i_bu;

    always_ff @(posedge i_clk) begin
        r_pix <= {clamp_channel(w_r), clamp_channel(w_g), clamp_channel(w_b)};
    end

    assign o_pix = r_pix;

endmodule

// ===== sv/yuy2_pair_to_rgb.sv =====
// Top level: YUY2 macropixel to two packed RGB pixels, two lanes and a merge stage.
`timescale 1ns / 1ps
`include "yuy2_pair_to_rgb_macros.svh"
// Usage:
//   Input channel: drive i_data (Y0, U, Y1, V) and raise start for one cycle
//   per macropixel. A beat is taken on each rising edge with start high and
//   busy low. busy is always low, so a new beat may arrive every cycle.
//   Output channel: o_valid pulses for exactly one cycle while o_result holds
//   the left and right pixels, each packed R[23:16] G[15:8] B[7:0].
//   The receiver cannot hold results off; it must take each beat when shown.
// Pipeline:
//   The taking edge registers the coefficient products (shared chroma
//   unit plus one luma multiplier per lane); the second register stage
//   then registers the channel sums and clamp in each lane. The strobe is
//   high in the cycle after that second register stage loads. One
//   macropixel is taken and one result given every clock cycle, sustained.
// Reset:
//   i_rst_n is synchronous, active low; it clears the valid pipeline so no
//   strobe appears for beats in flight. The datapath registers are not reset.
module yuy2_pair_to_rgb #(
    parameter int FRACTION_BITS = yp2r_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  yp2r_pkg::t_yuy2_in i_data,
    output logic               o_valid,
    output yp2r_pkg::t_rgb_out o_result
);
    localparam int PW = FRACTION_BITS + 12;

    logic                 w_accept;
    logic [1:0]           r_vld;
    logic [1:0]           n_vld;
    logic signed [PW-1:0] w_rv;
    logic signed [PW-1:0] w_gu;
    logic signed [PW-1:0] w_gv;
    logic signed [PW-1:0] w_bu;
    logic [23:0]          w_pix_first;
    logic [23:0]          w_pix_second;
    logic                 w_same_luma;
    logic                 w_grey_in;
    logic                 w_grey_out;
    logic                 w_pair_equal;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    yp2r_chroma #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_chroma (
        .i_clk        (i_clk),
        .i_chroma_blue(i_data.chroma_blue),
        .i_chroma_red (i_data.chroma_red),
        .o_rv         (w_rv),
        .o_gu         (w_gu),
        .o_gv         (w_gv),
        .o_bu         (w_bu)
    );

    yp2r_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane_first (
        .i_clk (i_clk),
        .i_luma(i_data.luma_first),
        .i_rv  (w_rv),
        .i_gu  (w_gu),
        .i_gv  (w_gv),
        .i_bu  (w_bu),
        .o_pix (w_pix_first)
    );

    yp2r_lane #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_lane_second (
        .i_clk (i_clk),
        .i_luma(i_data.luma_second),
        .i_rv  (w_rv),
        .i_gu  (w_gu),
        .i_gv  (w_gv),
        .i_bu  (w_bu),
        .o_pix (w_pix_second)
    );

    // Advance the strobe alongside the two datapath stages.
    assign n_vld = {r_vld[0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 2'b00;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Merge the lane words into one result beat.
    assign o_valid             = r_vld[1];
    assign o_result.rgb_first  = w_pix_first;
    assign o_result.rgb_second = w_pix_second;

    assign w_same_luma  = w_accept && (i_data.luma_first == i_data.luma_second);
    assign w_grey_in    = w_accept && (i_data.chroma_blue == yp2r_pkg::CHROMA_OFFSET)
                          && (i_data.chroma_red == yp2r_pkg::CHROMA_OFFSET);
    assign w_grey_out   = (o_result.rgb_first[23:16] == o_result.rgb_first[7:0])
                          && (o_result.rgb_first[15:8] == o_result.rgb_first[7:0]);
    assign w_pair_equal = (o_result.rgb_first == o_result.rgb_second);

    `YP2R_ASSERT_NEXT(a_latency, w_accept, ##1 o_valid)
    `YP2R_ASSERT_ALWAYS(a_no_orphan, !o_valid || $past(start, 2))
    `YP2R_ASSERT_NEXT(a_lanes_agree, w_same_luma, ##1 w_pair_equal)
    `YP2R_ASSERT_NEXT(a_neutral_grey, w_grey_in, ##1 w_grey_out)

endmodule

// ===== tb/yuy2_pair_to_rgb_checker.sv =====
// Checker for yuy2_pair_to_rgb: predicts each RGB pixel pair and compares result beats.
`timescale 1ns / 1ps
module yuy2_pair_to_rgb_checker #(
    parameter int FRAC = yp2r_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  yp2r_pkg::t_yuy2_in i_data,
    input  logic               i_valid,
    input  yp2r_pkg::t_rgb_out i_result,
    output int                 o_failures,
    output int                 o_checked,
    output int                 o_pending
);

    localparam int     DROP  = 24 - FRAC;
    localparam longint ROUND = (64'sd1 <<< DROP) >>> 1;
    localparam longint K_Y   = (yp2r_pkg::KY24  + ROUND) >>> DROP;
    localparam longint K_RV  = (yp2r_pkg::KRV24 + ROUND) >>> DROP;
    localparam longint K_GU  = (yp2r_pkg::KGU24 + ROUND) >>> DROP;
    localparam longint K_GV  = (yp2r_pkg::KGV24 + ROUND) >>> DROP;
    localparam longint K_BU  = (yp2r_pkg::KBU24 + ROUND) >>> DROP;

    yp2r_pkg::t_rgb_out expected_pixels[$];
    int failures = 0;
    int checked = 0;

    // Floor to the integer part, clamp below zero and saturate above 255.
    function automatic logic [7:0] channel_byte(input longint acc);
        longint whole;
        if (acc < 0) return 8'd0;
        whole = acc >>> FRAC;
        if (whole > 255) return 8'd255;
        return whole[7:0];
    endfunction

    function automatic logic [23:0] pixel_rgb(input logic [7:0] y, input longint ud,
                                              input longint vd);
        longint yl;
        longint yterm;
        yl = y;
        yterm = K_Y * (yl - 16);
        return {channel_byte(yterm + K_RV * vd),
                channel_byte(yterm - K_GU * ud - K_GV * vd),
                channel_byte(yterm + K_BU * ud)};
    endfunction

    function automatic yp2r_pkg::t_rgb_out predict_rgb_pair(input yp2r_pkg::t_yuy2_in px);
        longint ud;
        longint vd;
        yp2r_pkg::t_rgb_out pair;
        ud = px.chroma_blue;
        vd = px.chroma_red;
        ud = ud - 128;
        vd = vd - 128;
        pair.rgb_first  = pixel_rgb(px.luma_first, ud, vd);
        pair.rgb_second = pixel_rgb(px.luma_second, ud, vd);
        return pair;
    endfunction

    task automatic note_mismatch(input string field, input logic [23:0] want,
                                 input logic [23:0] got);
        failures++;
        $display("%0t: %s mismatch: expected %06h, actual %06h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        yp2r_pkg::t_rgb_out want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                expected_pixels.push_back(predict_rgb_pair(i_data));
            if (i_valid) begin
                if (expected_pixels.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result beat: expected none, actual %06h %06h",
                             $time, i_result.rgb_first, i_result.rgb_second);
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (i_result.rgb_first !== want.rgb_first)
                        note_mismatch("rgb_first", want.rgb_first, i_result.rgb_first);
                    if (i_result.rgb_second !== want.rgb_second)
                        note_mismatch("rgb_second", want.rgb_second, i_result.rgb_second);
                end
            end
        end
        o_failures <= failures;
        o_checked  <= checked;
        o_pending  <= expected_pixels.size();
    end

endmodule

// ===== tb/yuy2_pair_to_rgb_test.sv =====
// Testbench top for yuy2_pair_to_rgb: drives macropixels under several pacings.
`timescale 1ns / 1ps
module yuy2_pair_to_rgb_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 425;
    localparam int DRAIN_CYCLES  = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    yp2r_pkg::t_yuy2_in i_data;
    logic               o_valid;
    yp2r_pkg::t_rgb_out o_result;

    int failures;
    int checked;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int directed_sent = 0;

    yuy2_pair_to_rgb dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    yuy2_pair_to_rgb_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_data     (i_data),
        .i_valid    (o_valid),
        .i_result   (o_result),
        .o_failures (failures),
        .o_checked  (checked),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("yuy2_pair_to_rgb_test NOT OK");
            $finish;
        end
    end

    // Hold the beat until a rising edge with busy low takes it.
    task automatic send_macropixel(input yp2r_pkg::t_yuy2_in px);
        bit taken;
        start  <= 1'b1;
        i_data <= px;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Drop start and hold off until every predicted pair has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Favor the range ends and the offsets for part of the traffic.
    function automatic logic [7:0] pick_byte(input bit biased);
        if (biased) begin
            case ($urandom_range(5))
                0: return 8'd0;
                1: return 8'd255;
                2: return yp2r_pkg::LUMA_OFFSET;
                3: return 8'd235;
                4: return yp2r_pkg::CHROMA_OFFSET;
                default: return 8'($urandom);
            endcase
        end
        return 8'($urandom);
    endfunction

    function automatic yp2r_pkg::t_yuy2_in random_macropixel();
        yp2r_pkg::t_yuy2_in px;
        bit biased;
        biased = ($urandom_range(99) < 30);
        px.luma_first  = pick_byte(biased);
        px.chroma_blue = pick_byte(biased);
        px.luma_second = pick_byte(biased);
        px.chroma_red  = pick_byte(biased);
        return px;
    endfunction

    task automatic random_phase(input int count, input int idle_pct, input bit bursty);
        int pct;
        pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            if (bursty && (n % 32 == 0))
                pct = $urandom_range(1) ? 85 : 0;
            send_macropixel(random_macropixel());
            sender_gap(pct);
        end
    endtask

    initial begin : stimulus
        yp2r_pkg::t_yuy2_in directed[$];
        start   = 1'b0;
        i_data  = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Range ends, black and white levels, chroma extremes, clamp and
        // saturation cases, and alternating bit patterns.
        directed = '{
            '{8'd0,   8'd0,   8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd255, 8'd255},
            '{8'd16,  8'd128, 8'd235, 8'd128},
            '{8'd0,   8'd128, 8'd255, 8'd128},
            '{8'd128, 8'd0,   8'd128, 8'd0},
            '{8'd128, 8'd255, 8'd128, 8'd255},
            '{8'd128, 8'd0,   8'd128, 8'd255},
            '{8'd128, 8'd255, 8'd128, 8'd0},
            '{8'd16,  8'd0,   8'd16,  8'd0},
            '{8'd235, 8'd255, 8'd235, 8'd255},
            '{8'd81,  8'd90,  8'd145, 8'd240},
            '{8'd41,  8'd240, 8'd210, 8'd16},
            '{8'd1,   8'd127, 8'd254, 8'd129},
            '{8'h55,  8'hAA,  8'h55,  8'hAA},
            '{8'hAA,  8'h55,  8'hAA,  8'h55},
            '{8'd17,  8'd128, 8'd15,  8'd128}
        };
        foreach (directed[k]) begin
            send_macropixel(directed[k]);
            sender_gap(20);
        end
        directed_sent = items_sent;
        wait_for_results();

        random_phase(PHASE_ITEMS, 0, 1'b0);
        wait_for_results();
        random_phase(PHASE_ITEMS, 85, 1'b0);
        random_phase(PHASE_ITEMS, 11, 1'b0);
        wait_for_results();
        random_phase(PHASE_ITEMS, 0, 1'b1);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d macropixels (%0d directed, rest random under four pacings)",
                 items_sent, directed_sent);
        $display("compared %0d result beats, %0d failures", checked, failures);
        if (failures == 0) begin
            $display("yuy2_pair_to_rgb_test OK");
        end else begin
            $display("yuy2_pair_to_rgb_test NOT OK");
        end
        $finish;
    end

endmodule
